[hw/rtl/atilt_pkg.sv]
// Shared widths, register indexes, reset values and the arctangent table for the tilt block.
package atilt_pkg;

    // Field widths at the block boundary.
    localparam int AXIS_W    = 16;
    localparam int OFFS_W    = 12;
    localparam int ANGLE_W   = 15;
    localparam int MASK_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Offset-corrected sample and sum-of-squares widths.
    localparam int CORR_W = AXIS_W + 1;
    localparam int SQ_W   = 32;

    // Square root of (sum << 30): 31 result bits, one per stage.
    localparam int ROOT_W   = 31;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQRT_LAT = ROOT_W;
    localparam int FRAC_W   = 15;

    // Vectoring datapath widths.
    localparam int CW         = 35;
    localparam int ZW         = 27;
    localparam int ANGLE_FRAC = 12;
    localparam int ATAN_LEN   = 24;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE = 15'sd9000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

    // Offset reset values in raw units.
    localparam logic signed [OFFS_W-1:0] OFFSET_X_RST = 12'sd41;
    localparam logic signed [OFFS_W-1:0] OFFSET_Y_RST = -12'sd20;
    localparam logic signed [OFFS_W-1:0] OFFSET_Z_RST = -12'sd164;

    // Arctangent of 2^-i in 1/4096 hundredths of a degree.
    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 27'sd18432000;
            1:       v = 27'sd10881045;
            2:       v = 27'sd5749245;
            3:       v = 27'sd2918407;
            4:       v = 27'sd1464867;
            5:       v = 27'sd733147;
            6:       v = 27'sd366663;
            7:       v = 27'sd183343;
            8:       v = 27'sd91673;
            9:       v = 27'sd45837;
            10:      v = 27'sd22918;
            11:      v = 27'sd11459;
            12:      v = 27'sd5730;
            13:      v = 27'sd2865;
            14:      v = 27'sd1432;
            15:      v = 27'sd716;
            16:      v = 27'sd358;
            17:      v = 27'sd179;
            18:      v = 27'sd90;
            19:      v = 27'sd45;
            20:      v = 27'sd22;
            21:      v = 27'sd11;
            22:      v = 27'sd6;
            23:      v = 27'sd3;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/atilt_sqrt.sv]
// Pipelined square root of (sum << 30), one result bit per stage.
module atilt_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [atilt_pkg::SQ_W-1:0]   sum,
    output logic [atilt_pkg::ROOT_W-1:0] root
);

    localparam int NS     = atilt_pkg::ROOT_W;
    localparam int REM_W  = atilt_pkg::REM_W;
    localparam int SQ_W   = atilt_pkg::SQ_W;
    // Only the upper 16 digit pairs come from the sum; the rest are zero.
    localparam int S_REGS = 15;

    logic [REM_W-1:0]  rem_reg  [NS-1];
    logic [NS-1:0]     root_reg [NS];
    logic [SQ_W-1:0]   s_reg    [S_REGS];

    logic [REM_W-1:0]  rem_in   [NS];
    logic [NS-1:0]     root_in  [NS];
    logic [1:0]        pair     [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            localparam int I = NS - 1 - k;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic             take;

            if (k == 0) begin : g_first
                assign rem_in[k]  = '0;
                assign root_in[k] = '0;
            end
            else begin : g_next
                assign rem_in[k]  = rem_reg[k-1];
                assign root_in[k] = root_reg[k-1];
            end

            // Digit pair of the shifted radicand for this stage.
            if (I >= 15) begin : g_pair
                if (k == 0) begin : g_p0
                    assign pair[k] = sum[2*I-30 +: 2];
                end
                else begin : g_pn
                    assign pair[k] = s_reg[k-1][2*I-30 +: 2];
                end
            end
            else begin : g_zero
                assign pair[k] = 2'b00;
            end

            // Trial subtract of (root << 2) | 1.
            assign rem_sh = {rem_in[k][REM_W-3:0], pair[k]};
            assign trial  = {root_in[k], 2'b01};
            assign take   = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[k] <= {root_in[k][NS-2:0], take};
                end
            end

            if (k < NS - 1) begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= take ? (rem_sh - trial) : rem_sh;
                    end
                end
            end

            if (k < S_REGS) begin : g_s
                if (k == 0) begin : g_s0
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            s_reg[k] <= sum;
                        end
                    end
                end
                else begin : g_sn
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            s_reg[k] <= s_reg[k-1];
                        end
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[NS-1];

endmodule

[hw/rtl/atilt_cordic.sv]
// Pipelined vectoring rotator: angle of (den, num) in hundredths of a degree.
module atilt_cordic #(
    parameter int STEPS = atilt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [atilt_pkg::CW-1:0]      den,
    input  logic signed [atilt_pkg::CW-1:0]      num,
    output logic signed [atilt_pkg::ANGLE_W-1:0] angle,
    output logic                                 undef
);

    localparam int CW = atilt_pkg::CW;
    localparam int ZW = atilt_pkg::ZW;
    localparam int AW = atilt_pkg::ANGLE_W;

    typedef struct packed {
        logic den_zero;
        logic num_pos;
        logic num_neg;
    } flags_t;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [ZW-1:0] z_reg [STEPS];
    flags_t               f_reg [STEPS];

    logic signed [CW-1:0] x_in [STEPS];
    logic signed [CW-1:0] y_in [STEPS];
    logic signed [ZW-1:0] z_in [STEPS];
    flags_t               f_in [STEPS];

    flags_t               f0;

    logic signed [AW-1:0] angle_reg;
    logic                 undef_reg;

    assign f0.den_zero = (den == '0);
    assign f0.num_neg  = num[CW-1];
    assign f0.num_pos  = !num[CW-1] && (num != '0);

    // One micro-rotation per stage, driving y toward zero.
    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic                 up;

            if (k == 0) begin : g_first
                assign x_in[k] = den;
                assign y_in[k] = num;
                assign z_in[k] = '0;
                assign f_in[k] = f0;
            end
            else begin : g_next
                assign x_in[k] = x_reg[k-1];
                assign y_in[k] = y_reg[k-1];
                assign z_in[k] = z_reg[k-1];
                assign f_in[k] = f_reg[k-1];
            end

            assign xs = x_in[k] >>> k;
            assign ys = y_in[k] >>> k;
            assign up = !y_in[k][CW-1] && (y_in[k] != '0);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k] <= up ? (x_in[k] + ys) : (x_in[k] - ys);
                    y_reg[k] <= up ? (y_in[k] - xs) : (y_in[k] + xs);
                    z_reg[k] <= up ? (z_in[k] + atilt_pkg::atan_val(k))
                                   : (z_in[k] - atilt_pkg::atan_val(k));
                    f_reg[k] <= f_in[k];
                end
            end
        end
    endgenerate

    // Round, clamp to a right angle and apply the zero-denominator cases.
    logic signed [ZW-1:0] z_rnd;
    logic signed [AW-1:0] r;
    logic signed [AW-1:0] r_clamp;
    flags_t               f_last;

    assign f_last = f_reg[STEPS-1];
    assign z_rnd  = z_reg[STEPS-1] + ZW'(2048);
    assign r      = z_rnd[ZW-1:atilt_pkg::ANGLE_FRAC];

    always_comb
    begin
        if (r > atilt_pkg::RIGHT_ANGLE)
        begin
            r_clamp = atilt_pkg::RIGHT_ANGLE;
        end
        else if (r < -atilt_pkg::RIGHT_ANGLE)
        begin
            r_clamp = -atilt_pkg::RIGHT_ANGLE;
        end
        else
        begin
            r_clamp = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (f_last.den_zero)
            begin
                angle_reg <= f_last.num_pos ? atilt_pkg::RIGHT_ANGLE :
                             f_last.num_neg ? -atilt_pkg::RIGHT_ANGLE : '0;
                undef_reg <= !f_last.num_pos && !f_last.num_neg;
            end
            else
            begin
                angle_reg <= r_clamp;
                undef_reg <= 1'b0;
            end
        end
    end

    assign angle = angle_reg;
    assign undef = undef_reg;

endmodule

[hw/rtl/accel_tilt_angles.sv]
// Top level of the accelerometer tilt block: offsets, squares, roots, angles.
//
// Input beats carry one raw sample (accel_x, accel_y, accel_z); each gives
// exactly one output beat with roll_angle, pitch_angle and tilt_angle in
// hundredths of a degree plus undefined_mask (bit0 roll, bit1 pitch,
// bit2 tilt) for zero-over-zero cases, whose angle reads as zero.
// Offsets are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce it. An
// index beyond offset_z is ignored. Each sample passes the offset, square
// and sum registers, the root digit stages, CORDIC_STEPS rotation stages,
// a rounding register and one output register.
// One beat per cycle when not stalled; the whole pipeline advances together.
// When out_stall is high while out_valid is high, every stage holds and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and loads the offset reset values.
module accel_tilt_angles #(
    parameter int CORDIC_STEPS = atilt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [atilt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [atilt_pkg::OFFS_W-1:0]           cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [atilt_pkg::AXIS_W-1:0]    accel_x,
    input  logic signed [atilt_pkg::AXIS_W-1:0]    accel_y,
    input  logic signed [atilt_pkg::AXIS_W-1:0]    accel_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [atilt_pkg::ANGLE_W-1:0]   roll_angle,
    output logic signed [atilt_pkg::ANGLE_W-1:0]   pitch_angle,
    output logic signed [atilt_pkg::ANGLE_W-1:0]   tilt_angle,
    output logic [atilt_pkg::MASK_W-1:0]           undefined_mask
);

    localparam int CORR_W = atilt_pkg::CORR_W;
    localparam int SQ_W   = atilt_pkg::SQ_W;
    localparam int ROOT_W = atilt_pkg::ROOT_W;
    localparam int CW     = atilt_pkg::CW;
    localparam int AW     = atilt_pkg::ANGLE_W;
    localparam int OW     = atilt_pkg::OFFS_W;
    localparam int FW     = atilt_pkg::FRAC_W;
    localparam int SQL    = atilt_pkg::SQRT_LAT;
    localparam int LAT    = 3 + SQL + CORDIC_STEPS + 2;
    localparam int ZL     = CORDIC_STEPS + 1;

    // Offset registers.
    logic signed [OW-1:0] off_x_reg;
    logic signed [OW-1:0] off_y_reg;
    logic signed [OW-1:0] off_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= atilt_pkg::OFFSET_X_RST;
            off_y_reg <= atilt_pkg::OFFSET_Y_RST;
            off_z_reg <= atilt_pkg::OFFSET_Z_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                atilt_pkg::REG_OFFSET_X: off_x_reg <= cfg_data;
                atilt_pkg::REG_OFFSET_Y: off_y_reg <= cfg_data;
                atilt_pkg::REG_OFFSET_Z: off_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance and valid bits.
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Stage 1: offset-corrected axes.
    logic signed [CORR_W-1:0] x1_reg, y1_reg, z1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= CORR_W'(accel_x) + CORR_W'(off_x_reg);
            y1_reg <= CORR_W'(accel_y) + CORR_W'(off_y_reg);
            z1_reg <= CORR_W'(accel_z) + CORR_W'(off_z_reg);
        end
    end

    // Stage 2: squares.
    logic signed [2*CORR_W-1:0] px, py, pz;
    logic [SQ_W-1:0]            xx_reg, yy_reg, zz_reg;
    logic signed [CORR_W-1:0]   x2_reg, y2_reg, z2_reg;

    assign px = x1_reg * x1_reg;
    assign py = y1_reg * y1_reg;
    assign pz = z1_reg * z1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= px[SQ_W-1:0];
            yy_reg <= py[SQ_W-1:0];
            zz_reg <= pz[SQ_W-1:0];
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            z2_reg <= z1_reg;
        end
    end

    // Stage 3: sums of squares.
    logic [SQ_W-1:0]          sxz_reg, syz_reg, sxy_reg;
    logic signed [CORR_W-1:0] x3_reg, y3_reg, z3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxz_reg <= xx_reg + zz_reg;
            syz_reg <= yy_reg + zz_reg;
            sxy_reg <= xx_reg + yy_reg;
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            z3_reg  <= z2_reg;
        end
    end

    // Square roots with 15 fraction bits.
    logic [ROOT_W-1:0] root_xz, root_yz, root_xy;

    atilt_sqrt u_sqrt_xz (.clk(clk), .en(en), .sum(sxz_reg), .root(root_xz));
    atilt_sqrt u_sqrt_yz (.clk(clk), .en(en), .sum(syz_reg), .root(root_yz));
    atilt_sqrt u_sqrt_xy (.clk(clk), .en(en), .sum(sxy_reg), .root(root_xy));

    // Axes delayed to line up with the roots.
    logic signed [CORR_W-1:0] xd_reg [SQL];
    logic signed [CORR_W-1:0] yd_reg [SQL];
    logic signed [CORR_W-1:0] zd_reg [SQL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= x3_reg;
            yd_reg[0] <= y3_reg;
            zd_reg[0] <= z3_reg;
            for (int i = 1; i < SQL; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
                zd_reg[i] <= zd_reg[i-1];
            end
        end
    end

    // Operands of the three angle units.
    logic signed [CORR_W-1:0] xs, ys, zs;
    logic [CORR_W-1:0]        zabs;
    logic signed [CW-1:0]     roll_den, roll_num;
    logic signed [CW-1:0]     pitch_den, pitch_num;
    logic signed [CW-1:0]     tilt_den, tilt_num;

    assign xs   = xd_reg[SQL-1];
    assign ys   = yd_reg[SQL-1];
    assign zs   = zd_reg[SQL-1];
    assign zabs = zs[CORR_W-1] ? CORR_W'(-zs) : CORR_W'(zs);

    assign roll_den  = CW'({1'b0, root_xz});
    assign roll_num  = CW'(ys) <<< FW;
    assign pitch_den = CW'({1'b0, root_yz});
    assign pitch_num = -(CW'(xs) <<< FW);
    assign tilt_den  = CW'({1'b0, zabs}) <<< FW;
    assign tilt_num  = CW'({1'b0, root_xy});

    logic signed [AW-1:0] roll_a, pitch_a, tilt_a;
    logic                 roll_u, pitch_u, tilt_u;

    atilt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .clk(clk), .en(en), .den(roll_den), .num(roll_num),
        .angle(roll_a), .undef(roll_u)
    );

    atilt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .clk(clk), .en(en), .den(pitch_den), .num(pitch_num),
        .angle(pitch_a), .undef(pitch_u)
    );

    atilt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_tilt (
        .clk(clk), .en(en), .den(tilt_den), .num(tilt_num),
        .angle(tilt_a), .undef(tilt_u)
    );

    // Sign of z, delayed to meet the tilt angle.
    logic [ZL-1:0] zneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zneg_reg <= {zneg_reg[ZL-2:0], zs[CORR_W-1]};
        end
    end

    // Output register.
    logic signed [AW-1:0]          roll_reg, pitch_reg, tilt_reg;
    logic [atilt_pkg::MASK_W-1:0]  mask_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_a;
            pitch_reg <= pitch_a;
            tilt_reg  <= zneg_reg[ZL-1] ? -tilt_a : tilt_a;
            mask_reg  <= {tilt_u, pitch_u, roll_u};
        end
    end

    assign out_valid      = vld_reg[LAT-1];
    assign roll_angle     = roll_reg;
    assign pitch_angle    = pitch_reg;
    assign tilt_angle     = tilt_reg;
    assign undefined_mask = mask_reg;

endmodule
